>>> src/incremental_conductance_mppt_assert.svh
// Assertion macros shared by the MPPT RTL
`ifndef INCREMENTAL_CONDUCTANCE_MPPT_ASSERT_SVH
`define INCREMENTAL_CONDUCTANCE_MPPT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define ICM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define ICM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`else
`define ICM_ASSERT_IMP(label, cond, prop, msg)
`define ICM_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

>>> src/icm_pkg.sv
// Types and constants of the incremental-conductance MPPT block
`timescale 1ns / 1ps

package icm_pkg;

  // result field widths and packed beat width
  localparam int STEP_W = 17;
  localparam int DIR_W  = 2;
  localparam int OUT_W  = 24;

  // Q0.16 step and gain
  localparam int FRAC_W = 16;

  // register port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register reset values
  localparam logic [FRAC_W-1:0] STEP_SIZE_RST    = 16'd655;
  localparam logic              SCALED_MODE_RST  = 1'b1;
  localparam logic [FRAC_W-1:0] DAMPING_GAIN_RST = 16'd328;

  // register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_STEP_SIZE       = 3'd0,
    REG_SCALED_MODE     = 3'd1,
    REG_DAMPING_GAIN    = 3'd2,
    REG_INITIAL_CURRENT = 3'd3,
    REG_INITIAL_VOLTAGE = 3'd4
  } cfg_reg_t;

  // reported direction
  typedef enum logic [DIR_W-1:0] {
    DIR_HOLD = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_SUM,
    ST_DEC,
    ST_MUL2,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> src/incremental_conductance_mppt.sv
// Incremental-conductance MPPT with bit-serial multipliers and divider
`timescale 1ns / 1ps
`include "incremental_conductance_mppt_assert.svh"

// Incremental-conductance maximum power point tracker.
// Input stream s_*: one beat is a new current/voltage sample pair.
// Output stream m_*: one beat per input beat with the signed step, the
// direction and the zero-voltage fault flag.
// Registers on the APB-style port: step_size, scaled_mode, damping_gain,
// initial_current, initial_voltage at byte addresses 0, 4, 8, 12, 16.
// Writing an initial register loads the stored previous sample at once.
// Sequence: the four sample products run bit-serially, then dP and the
//   comparison numerator are registered and the direction decided. When the
//   step is scaled, the gain and power products run bit-serially; when the
//   damped factor stays below one, a restoring divider gives the 16 quotient
//   bits one per cycle. A fixed or held step skips both, and a factor that
//   reaches one skips the divider.
//   One item is in work at a time; s_tready returns in the cycle after the
//   result is loaded.
// The result sits in an output register: a stalled receiver does not stop
// the next sample from being taken, only the load of its result.
// Reset (rst, synchronous) restores register defaults, clears the previous
// sample pair to zero and drops any item in work.
module incremental_conductance_mppt
  import icm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // slave stream: [SW-1:0] current_sample, [2SW-1:SW] voltage_sample
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,
  // master stream: [16:0] step, [18:17] direction, [19] zero_voltage_fault
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  output logic [OUT_W-1:0]                           m_tdata,
  // register port
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [CFG_AW-1:0]                          paddr,
  input  logic [CFG_DW-1:0]                          pwdata,
  output logic [CFG_DW-1:0]                          prdata,
  output logic                                       pready
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int L1  = (SW + 1 > FRAC_W) ? SW + 1 : FRAC_W; // sample product passes
  localparam int HW  = SW + 2;                                // signed accumulator
  localparam int PW  = 2 * SW;                                // |dP| bits
  localparam int DPW = 2 * SW + 1;                            // dP
  localparam int NMW = 2 * SW + 2;                            // comparison numerator
  localparam int AW  = FRAC_W + 1 + PW;                       // gain * |dP|
  localparam int NW  = 2 * FRAC_W + 1 + PW;                   // step * gain * |dP|
  localparam int DW  = SW + 1 + FRAC_W;                       // |dV| << 16
  localparam int CW  = $clog2(PW);

  // configuration registers and previous sample pair
  logic [FRAC_W-1:0]    step_size;
  logic                 scaled_mode;
  logic [FRAC_W-1:0]    damping_gain;
  logic signed [SW-1:0] initial_current;
  logic signed [SW-1:0] initial_voltage;
  logic signed [SW-1:0] last_current;
  logic signed [SW-1:0] last_voltage;

  // sequencer
  state_t          state, state_next;
  logic [CW-1:0]   cnt;
  logic            in_take;
  logic            out_load;
  logic            need_scale;
  logic            a_lt_d;

  // sample product lanes: cur*vol, last_cur*last_vol, dI*vol, cur*dV
  logic signed [SW-1:0] mc [4];
  logic signed [L1-1:0] mp [4];
  logic signed [HW-1:0] hi [4];
  logic [L1-1:0]        lo [4];
  logic signed [HW-1:0] addend [4];
  logic signed [HW-1:0] lsum [4];
  logic signed [HW+L1-1:0] prod [4];
  logic            last1;

  // step * gain lane
  logic [L1-1:0]        sg_mp;
  logic [FRAC_W:0]      sg_hi;
  logic [L1-1:0]        sg_lo;
  logic [FRAC_W:0]      sg_sum;
  logic [FRAC_W+L1:0]   sg_full;

  // per-item flags and differences
  logic signed [SW:0]   dv_r;
  logic                 dv_zero, vol_zero, di_zero, di_neg, dv_neg, vol_neg;
  logic signed [DPW-1:0] dp_r;
  logic signed [NMW-1:0] num_r;
  logic [SW:0]          dabs_r;
  dir_t                 dir_r;
  dir_t                 dir_dec;
  logic                 fault_r;
  logic                 use_q;

  // gain*|dP| and step*gain*|dP| lanes
  logic [PW-1:0]        dpm;
  logic [FRAC_W:0]      a_hi, a_sum;
  logic [PW-1:0]        a_lo;
  logic [2*FRAC_W:0]    n_hi, n_sum;
  logic [PW-1:0]        n_lo;
  logic [AW-1:0]        a_full;
  logic [NW-1:0]        n_full;
  logic [DW-1:0]        d_full;

  // divider
  logic [DW-1:0]        rem;
  logic [FRAC_W-1:0]    qb;
  logic [DW:0]          div_t;
  logic [DW:0]          div_diff;
  logic                 div_ge;

  // incoming beat
  logic signed [SW-1:0] in_cur, in_vol;
  logic signed [SW:0]   in_di, in_dv;

  // output register
  logic [STEP_W-1:0]    out_step;
  dir_t                 out_dir;
  logic                 out_fault;
  logic [FRAC_W-1:0]    mag_final;
  logic [STEP_W-1:0]    step_final;

  logic                 cfg_wr;

  assign in_cur = s_tdata[SW-1:0];
  assign in_vol = s_tdata[2*SW-1:SW];
  assign in_di  = (SW+1)'(in_cur) - (SW+1)'(last_current);
  assign in_dv  = (SW+1)'(in_vol) - (SW+1)'(last_voltage);

  // ---------------------------------------------------------------- register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_reg_t'(paddr[4:2]))
      REG_STEP_SIZE:       prdata = CFG_DW'(step_size);
      REG_SCALED_MODE:     prdata = CFG_DW'(scaled_mode);
      REG_DAMPING_GAIN:    prdata = CFG_DW'(damping_gain);
      REG_INITIAL_CURRENT: prdata = CFG_DW'(initial_current);
      REG_INITIAL_VOLTAGE: prdata = CFG_DW'(initial_voltage);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_MUL1;
      ST_MUL1: if (cnt == CW'(L1-1)) state_next = ST_SUM;
      ST_SUM:  state_next = ST_DEC;
      ST_DEC:  state_next = need_scale ? ST_MUL2 : ST_DONE;
      ST_MUL2: if (cnt == CW'(PW-1)) state_next = ST_CMP;
      ST_CMP:  state_next = a_lt_d ? ST_DIV : ST_DONE;
      ST_DIV:  if (cnt == CW'(FRAC_W-1)) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DONE: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  assign in_take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + CW'(1);
    end
  end

  // ---------------------------------------------------------------- configuration and history
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size       <= STEP_SIZE_RST;
      scaled_mode     <= SCALED_MODE_RST;
      damping_gain    <= DAMPING_GAIN_RST;
      initial_current <= '0;
      initial_voltage <= '0;
      last_current    <= '0;
      last_voltage    <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[4:2]))
        REG_STEP_SIZE:    step_size    <= pwdata[FRAC_W-1:0];
        REG_SCALED_MODE:  scaled_mode  <= pwdata[0];
        REG_DAMPING_GAIN: damping_gain <= pwdata[FRAC_W-1:0];
        REG_INITIAL_CURRENT: begin
          initial_current <= pwdata[SW-1:0];
          last_current    <= pwdata[SW-1:0];
        end
        REG_INITIAL_VOLTAGE: begin
          initial_voltage <= pwdata[SW-1:0];
          last_voltage    <= pwdata[SW-1:0];
        end
        default: ;
      endcase
    end else if (in_take) begin
      last_current <= in_cur;
      last_voltage <= in_vol;
    end
  end

  // ---------------------------------------------------------------- bit-serial sample products
  assign last1 = (cnt == CW'(L1-1));

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      // two's complement multiplier: the sign bit weighs negative
      if (mp[k][0]) addend[k] = last1 ? -HW'(mc[k]) : HW'(mc[k]);
      else          addend[k] = '0;
      lsum[k] = hi[k] + addend[k];
      prod[k] = {hi[k], lo[k]};
    end
    sg_sum  = sg_hi + (sg_mp[0] ? (FRAC_W+1)'(step_size) : '0);
    sg_full = {sg_hi, sg_lo};
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mc[0] <= in_cur;       mp[0] <= L1'(in_vol);
      mc[1] <= last_current; mp[1] <= L1'(last_voltage);
      mc[2] <= in_vol;       mp[2] <= L1'(in_di);
      mc[3] <= in_cur;       mp[3] <= L1'(in_dv);
      for (int k = 0; k < 4; k++) begin
        hi[k] <= '0;
      end
      sg_mp    <= L1'(damping_gain);
      sg_hi    <= '0;
      dv_r     <= in_dv;
      dv_zero  <= (in_dv == '0);
      vol_zero <= (in_vol == '0);
      di_zero  <= (in_di == '0);
      di_neg   <= in_di[SW];
      dv_neg   <= in_dv[SW];
      vol_neg  <= in_vol[SW-1];
    end else if (state == ST_MUL1) begin
      for (int k = 0; k < 4; k++) begin
        hi[k] <= lsum[k] >>> 1;
        lo[k] <= {lsum[k][0], lo[k][L1-1:1]};
        mp[k] <= mp[k] >>> 1;
      end
      sg_hi <= {1'b0, sg_sum[FRAC_W:1]};
      sg_lo <= {sg_sum[0], sg_lo[L1-1:1]};
      sg_mp <= sg_mp >> 1;
    end
  end

  // ---------------------------------------------------------------- dP, comparison and direction
  always_comb begin
    if (dv_zero)
      dir_dec = di_zero ? DIR_HOLD : (di_neg ? DIR_DOWN : DIR_UP);
    else if (vol_zero || num_r == '0)
      dir_dec = DIR_HOLD;
    else
      dir_dec = (num_r[NMW-1] ^ dv_neg ^ vol_neg) ? DIR_DOWN : DIR_UP;
    need_scale = scaled_mode && !dv_zero && !vol_zero && (dir_dec != DIR_HOLD);
  end

  // ---------------------------------------------------------------- gain*|dP| and step*gain*|dP|
  always_comb begin
    a_sum  = a_hi + (dpm[0] ? (FRAC_W+1)'(damping_gain) : '0);
    n_sum  = n_hi + (dpm[0] ? (2*FRAC_W+1)'(sg_full[2*FRAC_W-1:0]) : '0);
    a_full = {a_hi, a_lo};
    n_full = {n_hi, n_lo};
    d_full = {dabs_r, FRAC_W'(0)};
    a_lt_d = a_full < AW'(d_full);
  end

  // restoring division step
  always_comb begin
    div_t    = {rem, qb[FRAC_W-1]};
    div_ge   = div_t >= (DW+1)'(d_full);
    div_diff = div_t - (DW+1)'(d_full);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_SUM: begin
        dp_r  <= DPW'(prod[0]) - DPW'(prod[1]);
        num_r <= NMW'(prod[2]) + NMW'(prod[3]);
      end
      ST_DEC: begin
        dir_r   <= dir_dec;
        fault_r <= !dv_zero && vol_zero;
        use_q   <= 1'b0;
        dabs_r  <= dv_r[SW] ? (SW+1)'(-dv_r) : (SW+1)'(dv_r);
        dpm     <= dp_r[DPW-1] ? PW'(-dp_r) : PW'(dp_r);
        a_hi    <= '0;
        n_hi    <= '0;
      end
      ST_MUL2: begin
        a_hi <= {1'b0, a_sum[FRAC_W:1]};
        a_lo <= {a_sum[0], a_lo[PW-1:1]};
        n_hi <= {1'b0, n_sum[2*FRAC_W:1]};
        n_lo <= {n_sum[0], n_lo[PW-1:1]};
        dpm  <= dpm >> 1;
      end
      ST_CMP: begin
        // quotient fits 16 bits: upper part of the dividend is below |dV|<<16
        use_q <= a_lt_d;
        rem   <= n_full[DW+FRAC_W-1:FRAC_W];
        qb    <= n_lo[FRAC_W-1:0];
      end
      ST_DIV: begin
        rem <= div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
        qb  <= {qb[FRAC_W-2:0], div_ge};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    mag_final = use_q ? qb : step_size;
    case (dir_r)
      DIR_UP:   step_final = {1'b0, mag_final};
      DIR_DOWN: step_final = -{1'b0, mag_final};
      default:  step_final = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_step  <= step_final;
      out_dir   <= dir_r;
      out_fault <= fault_r;
    end
  end

  assign m_tdata = {(OUT_W-STEP_W-DIR_W-1)'(0), out_fault, out_dir, out_step};

  // ---------------------------------------------------------------- checks
  `ICM_ASSERT_NEXT(a_take_starts, s_tvalid && s_tready, state == ST_MUL1, "accept did not start work")
  `ICM_ASSERT_IMP(a_div_rem, state == ST_DIV, rem < d_full, "divider remainder out of range")
  `ICM_ASSERT_IMP(a_fault_hold, m_tvalid && out_fault, out_step == '0 && out_dir == DIR_HOLD, "fault result not held")
  `ICM_ASSERT_IMP(a_up_sign, m_tvalid && out_dir == DIR_UP, !out_step[STEP_W-1], "upward step negative")

endmodule

>>> test/tb.sv
// Self-checking testbench of the incremental-conductance MPPT block
`timescale 1ns / 1ps

module tb
  import icm_pkg::*;
();

  localparam int SW             = 16;
  localparam int DRAIN_CYCLES   = 100;   // above the scaled latency
  localparam int LONG_HOLD      = 300;   // receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int PHASE_ITEMS    = 215;
  localparam int NUM_PHASES     = 7;
  localparam int TAIL_ITEMS     = 50;

  // index outside the register map, writes must be ignored
  localparam logic [2:0] REG_UNMAPPED = 3'd5;

  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    dir_t                     dir;
    logic                     fault;
  } step_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata  = '0;   // [15:0] current_sample, [31:16] voltage_sample
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;         // [16:0] step, [18:17] direction, [19] fault
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [CFG_AW-1:0]   paddr    = '0;
  logic [CFG_DW-1:0]   pwdata   = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  // tracker copy: registers and previous sample pair
  logic [FRAC_W-1:0]   cfg_step   = STEP_SIZE_RST;
  logic                cfg_scaled = SCALED_MODE_RST;
  logic [FRAC_W-1:0]   cfg_gain   = DAMPING_GAIN_RST;
  longint              prev_cur   = 0;
  longint              prev_vol   = 0;

  step_result_t        expected_steps[$];
  step_result_t        exp_beat;
  int                  errors       = 0;
  int                  quiet_cycles = 0;
  bit                  tx_gaps_on   = 1'b0;
  bit                  rx_stalls_on = 1'b0;
  bit                  hold_request = 1'b0;

  incremental_conductance_mppt #(.SAMPLE_WIDTH(SW)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int sign_of(input longint x);
    if (x > 0) return 1;
    if (x < 0) return -1;
    return 0;
  endfunction

  // incremental-conductance decision for one sample pair, advances the pair
  function automatic step_result_t track_step(input logic signed [SW-1:0] cur,
                                              input logic signed [SW-1:0] vol);
    longint       c, v, di, dv, dp, num, gain_dp, dv_q16, mag_step, stepv;
    int           dsign;
    step_result_t r;
    c        = cur;
    v        = vol;
    di       = c - prev_cur;
    dv       = v - prev_vol;
    dp       = c * v - prev_cur * prev_vol;
    mag_step = cfg_step;
    dsign    = 0;
    r.fault  = 1'b0;
    if (dv == 0) begin
      dsign = sign_of(di);
    end else if (v == 0) begin
      r.fault = 1'b1;
    end else begin
      num   = di * v + c * dv;
      dsign = sign_of(num) * sign_of(dv) * sign_of(v);
      // damped magnitude: step * min(1, gain*|dP| / (65536*|dV|))
      if (cfg_scaled) begin
        gain_dp = longint'(cfg_gain) * ((dp < 0) ? -dp : dp);
        dv_q16  = ((dv < 0) ? -dv : dv) << FRAC_W;
        if (gain_dp < dv_q16) mag_step = (longint'(cfg_step) * gain_dp) / dv_q16;
      end
    end
    prev_cur = c;
    prev_vol = v;
    stepv  = (dsign > 0) ? mag_step : (dsign < 0) ? -mag_step : 0;
    r.step = stepv[STEP_W-1:0];
    r.dir  = (dsign > 0) ? DIR_UP : (dsign < 0) ? DIR_DOWN : DIR_HOLD;
    return r;
  endfunction

  // register write: setup then access phase, tracker copy follows
  task automatic apb_write(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_STEP_SIZE:       cfg_step   = value[FRAC_W-1:0];
      REG_SCALED_MODE:     cfg_scaled = value[0];
      REG_DAMPING_GAIN:    cfg_gain   = value[FRAC_W-1:0];
      REG_INITIAL_CURRENT: prev_cur   = longint'($signed(value[SW-1:0]));
      REG_INITIAL_VOLTAGE: prev_vol   = longint'($signed(value[SW-1:0]));
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one sample beat; valid stays up on return so back-to-back beats are gapless
  task automatic send_sample(input logic signed [SW-1:0] cur,
                             input logic signed [SW-1:0] vol);
    int gap;
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {vol, cur};
    do @(posedge clk); while (!s_tready);
    expected_steps.push_back(track_step(cur, vol));
  endtask

  // drop valid, wait for every result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_sample();
    int c, v, kind;
    kind = $urandom_range(0, 99);
    c    = int'(prev_cur);
    v    = int'(prev_vol);
    if (kind < 45) begin
      // small perturbation around the operating point
      c = c + int'($urandom_range(0, 128)) - 64;
      v = v + int'($urandom_range(0, 128)) - 64;
    end else if (kind < 65) begin
      c = c + int'($urandom_range(0, 4000)) - 2000;
      v = v + int'($urandom_range(0, 4000)) - 2000;
    end else if (kind < 75) begin
      // voltage unchanged, only the current moves
      c = c + int'($urandom_range(0, 600)) - 300;
    end else if (kind < 80) begin
      c = int'($urandom_range(0, 65535)) - 32768;
      v = 0;
    end else begin
      c = int'($urandom_range(0, 65535)) - 32768;
      v = int'($urandom_range(0, 65535)) - 32768;
    end
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    send_sample(c[SW-1:0], v[SW-1:0]);
  endtask

  // reset values: hold, dI-only moves, scaled step, fault, sample extremes
  task automatic test_reset_defaults();
    send_sample(0, 0);
    send_sample(100, 0);
    send_sample(50, 0);
    send_sample(50, 1000);
    send_sample(50, 0);
    send_sample(0, 100);
    send_sample(0, 200);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    settle();
  endtask

  // fixed step at both ends of the step range
  task automatic test_fixed_step();
    apb_write(REG_SCALED_MODE, 32'd0);
    apb_write(REG_STEP_SIZE, 32'hffff);
    send_sample(1000, 2000);
    send_sample(900, 2100);
    send_sample(-500, -3000);
    settle();
    apb_write(REG_STEP_SIZE, 32'd0);
    send_sample(200, 300);
    send_sample(300, 300);
    settle();
  endtask

  // zero gain truncates every scaled step to zero, full gain saturates
  task automatic test_scaled_extremes();
    apb_write(REG_SCALED_MODE, 32'd1);
    apb_write(REG_STEP_SIZE, 32'd655);
    apb_write(REG_DAMPING_GAIN, 32'd0);
    send_sample(1000, 1000);
    send_sample(2000, 1500);
    settle();
    apb_write(REG_DAMPING_GAIN, 32'hffff);
    apb_write(REG_STEP_SIZE, 32'hffff);
    send_sample(3000, 1600);
    send_sample(3100, 1601);
    settle();
  endtask

  // initial registers load the previous pair at once
  task automatic test_initial_samples();
    apb_write(REG_INITIAL_CURRENT, 32'h0000_8000);
    apb_write(REG_INITIAL_VOLTAGE, 32'h0000_7fff);
    send_sample(16'sh8000, 16'sh7fff);
    settle();
    apb_write(REG_INITIAL_CURRENT, 32'h0000_7fff);
    apb_write(REG_INITIAL_VOLTAGE, 32'h0000_8000);
    send_sample(0, 0);
    settle();
  endtask

  // tracking runs over several register settings, with one long output stall
  task automatic test_random_tracking();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      rx_stalls_on = (ph != 3);
      tx_gaps_on   = (ph != 3);
      case (ph)
        0: begin
          apb_write(REG_STEP_SIZE, 32'd655);
          apb_write(REG_DAMPING_GAIN, 32'd328);
          apb_write(REG_SCALED_MODE, 32'd1);
        end
        1: begin
          apb_write(REG_STEP_SIZE, 32'hffff);
          apb_write(REG_DAMPING_GAIN, 32'hffff);
        end
        2: begin
          apb_write(REG_SCALED_MODE, $urandom() & 32'hffff_fffe);
          apb_write(REG_STEP_SIZE, $urandom());
        end
        3: begin
          apb_write(REG_SCALED_MODE, 32'd1);
          apb_write(REG_STEP_SIZE, $urandom());
          apb_write(REG_DAMPING_GAIN, $urandom());
        end
        4: begin
          apb_write(REG_STEP_SIZE, 32'hffff_0000);
          apb_write(REG_SCALED_MODE, $urandom());
        end
        5: begin
          apb_write(REG_SCALED_MODE, 32'd1);
          apb_write(REG_STEP_SIZE, $urandom());
          apb_write(REG_DAMPING_GAIN, $urandom());
          apb_write(REG_INITIAL_CURRENT, $urandom());
          apb_write(REG_INITIAL_VOLTAGE, $urandom());
          apb_write(REG_UNMAPPED, $urandom());
        end
        default: begin
          // small gains keep most steps in the truncated region
          apb_write(REG_STEP_SIZE, $urandom());
          apb_write(REG_DAMPING_GAIN, $urandom_range(1, 16));
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 40) hold_request = 1'b1;
        send_random_sample();
      end
      settle();
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_unbroken_stream();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    apb_write(REG_STEP_SIZE, 32'd655);
    apb_write(REG_DAMPING_GAIN, 32'd328);
    for (int i = 0; i < TAIL_ITEMS; i++) send_random_sample();
    settle();
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin : rx_drive
    int n;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        m_tready <= 1'b1;
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // result check against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: result beat with nothing pending, got %h", $time, m_tdata);
        errors++;
      end else begin
        exp_beat = expected_steps.pop_front();
        if (m_tdata[16:0] !== exp_beat.step) begin
          $display("%0t: step mismatch, expected %0d got %0d", $time,
                   exp_beat.step, $signed(m_tdata[16:0]));
          errors++;
        end
        if (m_tdata[18:17] !== exp_beat.dir) begin
          $display("%0t: direction mismatch, expected %0d got %0d", $time,
                   exp_beat.dir, m_tdata[18:17]);
          errors++;
        end
        if (m_tdata[19] !== exp_beat.fault) begin
          $display("%0t: fault mismatch, expected %0d got %0d", $time,
                   exp_beat.fault, m_tdata[19]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or register access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    test_reset_defaults();
    test_fixed_step();
    test_scaled_extremes();
    test_initial_samples();
    test_random_tracking();
    test_unbroken_stream();
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
